// ===== hw/rtl/tls_pkg.sv =====
package tls_pkg;

   // Widths of the fields that the channels carry.
   localparam int PIX_W      = 8;
   localparam int LAP_W      = 11;
   localparam int SIZE_W     = 12;
   localparam int THR_W      = 8;

   // Control and status register port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIFF_THRESHOLD = 2'd2;

   // Reset values of the size registers.
   localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;
   localparam logic [THR_W-1:0]  THRESHOLD_RESET    = 8'd0;

   // Input beat.
   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic             flush_row;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic signed [LAP_W-1:0] laplacian_value;
      logic                    frame_last;
   } rsp_type;

   // Position flags of one item, worked out when it is accepted.
   typedef struct packed {
      logic emit;       // a result for the row above is produced
      logic below;      // the item carries a real pixel (not the drain row)
      logic has_left;
      logic has_right;
      logic has_up;
      logic last;       // result belongs to the final pixel of the frame
   } item_ctl_type;

   // One line memory entry: the pixel of the row above and of the row above that.
   typedef struct packed {
      logic [PIX_W-1:0] line1;
      logic [PIX_W-1:0] line2;
   } line_entry_type;

   localparam int LINE_ENTRY_W = $bits(line_entry_type);

endpackage

// ===== hw/rtl/tls_line_mem.sv =====
module tls_line_mem #(
   parameter int DEPTH  = 2048,
   parameter int DATA_W = 16
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [DATA_W-1:0]        rd_data_a,
   output logic [DATA_W-1:0]        rd_data_b,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Two registered read ports; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hw/rtl/tls_seq.sv =====
module tls_seq #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [tls_pkg::SIZE_W-1:0]       image_width,
   input  logic [tls_pkg::SIZE_W-1:0]       image_height,
   output logic [$clog2(MAX_WIDTH)-1:0]     col_addr,
   output logic [$clog2(MAX_WIDTH)-1:0]     col_next_addr,
   output tls_pkg::item_ctl_type            item_ctl
);

   import tls_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int FW_W   = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
   localparam int CMP_A  = (SIZE_W > FW_W) ? SIZE_W : FW_W;
   localparam int CMP_W  = (CMP_A > ROW_W) ? CMP_A : ROW_W;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [FW_W-1:0]  fw_ff;
   logic [ROW_W-1:0] fh_ff;

   logic [CMP_W-1:0] width_wide;
   logic [CMP_W-1:0] height_wide;
   logic [FW_W-1:0]  fw_cfg;
   logic [ROW_W-1:0] fh_cfg;
   logic             frame_start;
   logic [FW_W-1:0]  fw;
   logic [ROW_W-1:0] fh;
   logic [FW_W-1:0]  col_plus;
   logic             row_end;

   // Saturate the configured sizes into their legal ranges.
   always_comb begin
      width_wide  = CMP_W'(image_width);
      height_wide = CMP_W'(image_height);
      if (width_wide == '0) begin
         fw_cfg = FW_W'(1);
      end else if (width_wide > CMP_W'(MAX_WIDTH)) begin
         fw_cfg = FW_W'(MAX_WIDTH);
      end else begin
         fw_cfg = FW_W'(width_wide);
      end
      if (height_wide == '0) begin
         fh_cfg = ROW_W'(1);
      end else if (height_wide > CMP_W'(MAX_HEIGHT)) begin
         fh_cfg = ROW_W'(MAX_HEIGHT);
      end else begin
         fh_cfg = ROW_W'(height_wide);
      end
   end

   // Sizes are taken from the registers at the first item of each frame.
   assign frame_start = (col_ff == '0) && (row_ff == '0);
   assign fw          = frame_start ? fw_cfg : fw_ff;
   assign fh          = frame_start ? fh_cfg : fh_ff;
   assign col_plus    = FW_W'(col_ff) + FW_W'(1);
   assign row_end     = (col_plus >= fw);

   // Position flags of the item at the head of the input.
   always_comb begin
      item_ctl.emit      = (row_ff != '0);
      item_ctl.below     = (row_ff < fh);
      item_ctl.has_left  = (col_ff != '0);
      item_ctl.has_right = (col_plus < fw);
      item_ctl.has_up    = ({1'b0, row_ff} >= (ROW_W + 1)'(2));
      item_ctl.last      = !(row_ff < fh) && (col_plus == fw);
   end

   // Raster position; the drain row (row equal to the height) wraps to a new frame.
   always_comb begin
      col_in = col_ff + COL_W'(1);
      row_in = row_ff;
      if (row_end) begin
         col_in = '0;
         if (row_ff == fh) begin
            row_in = '0;
         end else begin
            row_in = row_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && frame_start) begin
         fw_ff <= fw_cfg;
         fh_ff <= fh_cfg;
      end
   end

   assign col_addr      = col_ff;
   assign col_next_addr = col_ff + COL_W'(1);

endmodule

// ===== hw/rtl/tls_stencil.sv =====
module tls_stencil #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   output logic                             ready,
   input  logic [$clog2(MAX_WIDTH)-1:0]     col_addr,
   input  logic [$clog2(MAX_WIDTH)-1:0]     col_next_addr,
   input  tls_pkg::item_ctl_type            item_ctl,
   input  logic [tls_pkg::PIX_W-1:0]        pixel_value,
   input  logic [tls_pkg::THR_W-1:0]        threshold,
   input  tls_pkg::line_entry_type          rd_data_a,
   input  tls_pkg::line_entry_type          rd_data_b,
   output logic                             wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]     wr_addr,
   output tls_pkg::line_entry_type          wr_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tls_pkg::rsp_type                 rsp_data
);

   import tls_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   // A neighbour difference that counts only above the threshold.
   function automatic logic signed [LAP_W-1:0] masked_diff(
      input logic [PIX_W-1:0] nb,
      input logic [PIX_W-1:0] c,
      input logic [THR_W-1:0] thr
   );
      logic signed [PIX_W:0] d;
      logic [PIX_W:0]        mag;
      d   = $signed({1'b0, nb}) - $signed({1'b0, c});
      mag = d[PIX_W] ? (PIX_W + 1)'(-d) : (PIX_W + 1)'(d);
      if (mag > {1'b0, thr}) begin
         masked_diff = LAP_W'(d);
      end else begin
         masked_diff = '0;
      end
   endfunction

   logic               s1_valid_ff;
   item_ctl_type       s1_ctl_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [PIX_W-1:0]   s1_pix_ff;
   logic               fwd_a_ff;
   logic               fwd_b_ff;
   line_entry_type     fwd_data_ff;
   logic [PIX_W-1:0]   left_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;

   logic                    out_free;
   logic                    s1_adv;
   line_entry_type          entry;
   logic [PIX_W-1:0]        centre;
   logic [PIX_W-1:0]        right_pix;
   logic signed [LAP_W-1:0] t_left, t_right, t_up, t_down;
   logic signed [LAP_W-1:0] sum;

   // The stage moves on when the output register is empty or being emptied.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign ready    = !s1_valid_ff || out_free;

   // Memory data, with the write of the item just ahead forwarded.
   assign entry     = fwd_a_ff ? fwd_data_ff : rd_data_a;
   assign right_pix = fwd_b_ff ? fwd_data_ff.line1 : rd_data_b.line1;
   assign centre    = entry.line1;

   // Read-modify-write: the new pixel moves in and the row above moves down.
   assign wr_en         = s1_adv && s1_ctl_ff.below;
   assign wr_addr       = s1_col_ff;
   assign wr_data.line1 = s1_pix_ff;
   assign wr_data.line2 = centre;

   // Four thresholded terms; neighbours outside the image give nothing.
   assign t_left  = s1_ctl_ff.has_left  ? masked_diff(left_ff, centre, threshold)     : '0;
   assign t_right = s1_ctl_ff.has_right ? masked_diff(right_pix, centre, threshold)   : '0;
   assign t_up    = s1_ctl_ff.has_up    ? masked_diff(entry.line2, centre, threshold) : '0;
   assign t_down  = s1_ctl_ff.below     ? masked_diff(s1_pix_ff, centre, threshold)   : '0;
   assign sum     = t_left + t_right + t_up + t_down;

   assign rsp_data_in.laplacian_value = sum;
   assign rsp_data_in.frame_last      = s1_ctl_ff.last;

   // Stage one: the item whose memory read is in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff   <= item_ctl;
         s1_col_ff   <= col_addr;
         s1_pix_ff   <= pixel_value;
         fwd_a_ff    <= wr_en && (wr_addr == col_addr);
         fwd_b_ff    <= wr_en && (wr_addr == col_next_addr);
         fwd_data_ff <= wr_data;
      end
   end

   // The centre of this item is the left neighbour of the next one in the row.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         left_ff <= centre;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_ctl_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_ctl_ff.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // A blocked stage keeps its item.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_col_ff)))
      else $error("stage one lost its item while blocked");

   // With the output and the stage both full, no new beat may enter.
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && s1_valid_ff) |-> !ready)
      else $error("input ready while the pipeline is full");

   // The final result of a frame lies on the drain row at its last column.
   a_last_on_drain: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ctl_ff.last) |-> (!s1_ctl_ff.below && !s1_ctl_ff.has_right))
      else $error("frame end flagged away from the drain row end");
`endif

endmodule

// ===== hw/rtl/thresholded_laplacian_stencil.sv =====
// Thresholded four-neighbour Laplacian over a raster stream of 8-bit pixels.
// Input beats (req_) carry one pixel each in raster order; after the last row
// of a frame the source sends one row of drain beats (flush_row set), whose
// pixel values are ignored. Result beats (rsp_) carry the sum for the pixel
// one row above the current input position, so results start with the
// second row and the drain row delivers the final row; frame_last marks the
// final pixel of the frame. Sizes are sampled at the first beat of a frame.
// Throughput is one beat per clock while the receiver does not stall. A
// result passes through the registered line memory read and then the output
// register. The line memory holds one entry per column with the two previous
// rows, read at the column and the next column and written back in the same
// pass; the write of the item just ahead is forwarded. After reset the
// position counters are at the frame start, the registers hold their defaults
// and the line memory is not cleared. When the receiver stalls, one item waits
// in the read stage and req_ready drops only once both it and the output
// register are full. Registers are to be written by the user only while the
// block is idle; the block does not enforce this. csr_ready is always high.
module thresholded_laplacian_stencil #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tls_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tls_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tls_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tls_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import tls_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;
   logic [THR_W-1:0]  threshold_ff;

   logic              req_accept;
   logic              stage_ready;
   logic [COL_W-1:0]  col_addr;
   logic [COL_W-1:0]  col_next_addr;
   item_ctl_type      item_ctl;
   line_entry_type    rd_data_a;
   line_entry_type    rd_data_b;
   logic              wr_en;
   logic [COL_W-1:0]  wr_addr;
   line_entry_type    wr_data;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= IMAGE_WIDTH_RESET;
         height_ff    <= IMAGE_HEIGHT_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:    width_ff     <= csr_wdata;
            CSR_IMAGE_HEIGHT:   height_ff    <= csr_wdata;
            CSR_DIFF_THRESHOLD: threshold_ff <= csr_wdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready  = stage_ready;
   assign req_accept = req_valid && stage_ready;

   // Raster position and frame sizes.
   tls_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .image_width   (width_ff),
      .image_height  (height_ff),
      .col_addr      (col_addr),
      .col_next_addr (col_next_addr),
      .item_ctl      (item_ctl)
   );

   // Line memory: two previous rows per column.
   tls_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (LINE_ENTRY_W)
   ) u_line_mem (
      .clock     (clock),
      .rd_en     (req_accept),
      .rd_addr_a (col_addr),
      .rd_addr_b (col_next_addr),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   // Difference sums and output register.
   tls_stencil #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_stencil (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .ready         (stage_ready),
      .col_addr      (col_addr),
      .col_next_addr (col_next_addr),
      .item_ctl      (item_ctl),
      .pixel_value   (req_data.pixel_value),
      .threshold     (threshold_ff),
      .rd_data_a     (rd_data_a),
      .rd_data_b     (rd_data_b),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule
